[hw/rtl/lml_pkg.sv]
`default_nettype none
package lml_pkg;

    localparam int LAT_SPAN = 180 * 128;
    localparam int LON_SPAN = 360 * 128;

    localparam logic [1:0] OP_TABLE_WR = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_SLOT_WR  = 2'd2;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    localparam logic [2:0] ST_UNIFORM = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_NOSLOT  = 3'd3;
    localparam logic [2:0] ST_ACK     = 3'd4;

    // decoded point of a query
    typedef struct packed {
        logic [15:0] box;
        logic [9:0]  word;
        logic [3:0]  bit_sel;
    } point_t;

    function automatic point_t decode_point(input logic signed [14:0] lat_in,
                                            input logic signed [15:0] lon_in);
        logic signed [17:0] lat;
        logic signed [17:0] lon;
        logic [7:0]  lat_i;
        logic [8:0]  lon_i;
        logic [6:0]  lat_s;
        logic [6:0]  lon_s;
        logic [16:0] prod;
        point_t      p;
        lat = 18'(lat_in) + 18'(LAT_SPAN / 2);
        lon = 18'(lon_in) + 18'(LON_SPAN / 2);
        if (lat < 0) lat = '0;
        if (lat > 18'(LAT_SPAN)) lat = 18'(LAT_SPAN);
        if (lon < 0) lon = '0;
        if (lon > 18'(LON_SPAN)) lon = 18'(LON_SPAN);
        if (lat == 18'(LAT_SPAN)) begin
            lat_i = 8'd179;
            lat_s = 7'd127;
        end else begin
            lat_i = lat[14:7];
            lat_s = lat[6:0];
        end
        if (lon == 18'(LON_SPAN)) begin
            lon_i = 9'd359;
            lon_s = 7'd127;
        end else begin
            lon_i = lon[15:7];
            lon_s = lon[6:0];
        end
        prod = {lat_i, 8'd0} + {2'd0, lat_i, 6'd0} + {3'd0, lat_i, 5'd0}
             + {3'd0, lat_i, 3'd0};
        p.box = 16'(prod + 17'(lon_i));
        p.word = {lat_s, lon_s[6:4]};
        p.bit_sel = lon_s[3:0];
        return p;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lml_slot_dir.sv]
`default_nettype none
// Slot directory: tags and stamps, scanned one slot a cycle by the sequencer.
module lml_slot_dir
    import lml_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int SW = 6
)(
    input  wire logic          clk,
    input  wire logic [SW-1:0] rd_idx,
    output logic [15:0]        rd_tag,
    output logic [31:0]        rd_stamp,
    input  wire logic          wr_en,
    input  wire logic [SW-1:0] wr_idx,
    input  wire logic [15:0]   wr_tag,
    input  wire logic [31:0]   wr_stamp
);
    logic [15:0] tag_mem [SLOTS];
    logic [31:0] stamp_mem [SLOTS];

    // entries at or above slots_in_use are never used, so no reset is needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_idx] <= wr_tag;
            stamp_mem[wr_idx] <= wr_stamp;
        end
        rd_tag <= tag_mem[rd_idx];
        rd_stamp <= stamp_mem[rd_idx];
    end
endmodule
`default_nettype wire

[hw/rtl/land_mask_lookup_lru_boxes.sv]
`default_nettype none
// Channel | Dir | tuser  | tdata fields (low bit up)
// s_axis  | in  | opcode | lat_fixed, lon_fixed, table_index, table_value,
//         |     |        | fill_slot, fill_word, fill_data (96 bits)
// m_axis  | out | status | land, fetch_record, fetch_target, box_number (40 bits)
// Writes pass S_TBL and S_OUT; uniform queries add S_ENTRY, a hit on the last box
// adds S_ENTRY and S_WORD. Other mixed queries scan one slot a cycle in S_SCAN (at
// most SLOTS-1 slots, none while the directory is empty); a miss then ends S_DEC,
// S_OUT, a tag hit S_DEC, S_WORD, S_OUT, so the tag/stamp scan sets the rate.
// rst_n clears the sequencer, counters and the last-box record; tables are
// valid only after being written. A held result blocks the next word.
module land_mask_lookup_lru_boxes
    import lml_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int WORDS_PER_BOX = 1024,
    parameter int TABLE_DEPTH = 65536
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // lat,lon,tidx,tval,slot,word,data
    input  wire logic [1:0]  s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // land,rec,target,box
    output logic [2:0]       m_axis_tuser   // status
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = $clog2(TABLE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TBL   = 7'b0000010,
        S_ENTRY = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DEC   = 7'b0010000,
        S_WORD  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  op_reg;
    logic [15:0] tidx_reg;
    logic [14:0] tval_reg;
    logic [5:0]  fslot_reg;
    logic [9:0]  fword_reg;
    logic [15:0] fdata_reg;
    point_t      pt_reg;

    logic [CW-1:0] in_use_reg;
    logic [31:0]   qcnt_reg;
    logic [16:0]   prev_box_reg;
    logic [SW-1:0] prev_slot_reg;

    logic [CW-1:0] scan_reg;
    logic [31:0]   low_reg;
    logic [SW-1:0] low_i_reg;
    logic          have_low_reg;
    logic          found_reg;
    logic [SW-1:0] slot_reg;
    logic [14:0]   entry_reg;

    logic [2:0]  status_reg;
    logic        land_reg;
    logic [14:0] rec_reg;
    logic [5:0]  target_reg;
    logic [15:0] box_out_reg;

    logic [15:0] box_table [TABLE_DEPTH];
    logic [15:0] slot_store [SLOTS*WORDS_PER_BOX];
    logic [15:0] tbl_rd;
    logic [15:0] word_rd;

    logic [15:0] dir_tag;
    logic [31:0] dir_stamp;
    logic        dir_we;
    logic [SW-1:0] dir_widx;
    logic [SW-1:0] rd_idx;

    logic [SW+9:0] word_addr;
    logic          tbl_ok, slot_ok;

    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;
    // prefetch the next directory entry while scanning
    assign rd_idx = (state_reg == S_SCAN && scan_reg + 1'b1 < in_use_reg)
                    ? SW'(scan_reg + 1'b1) : SW'(0);

    assign m_axis_tdata = {2'b00, box_out_reg, target_reg, rec_reg, land_reg};
    assign m_axis_tuser = status_reg;

    assign tbl_ok  = ({16'd0, tidx_reg} < 32'(TABLE_DEPTH));
    assign slot_ok = ({26'd0, fslot_reg} < 32'(SLOTS));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_TBL && op_reg == OP_TABLE_WR && tbl_ok)
            box_table[TW'(tidx_reg)] <= {1'b0, tval_reg};
        tbl_rd <= box_table[TW'(pt_reg.box)];
        if (state_reg == S_TBL && op_reg == OP_SLOT_WR && slot_ok)
            slot_store[{SW'(fslot_reg), fword_reg}] <= fdata_reg;
        word_rd <= slot_store[word_addr];
    end

    assign word_addr = {slot_reg, pt_reg.word};

    lml_slot_dir #(.SLOTS(SLOTS), .SW(SW)) u_dir (
        .clk      (clk),
        .rd_idx   (rd_idx),
        .rd_tag   (dir_tag),
        .rd_stamp (dir_stamp),
        .wr_en    (dir_we),
        .wr_idx   (dir_widx),
        .wr_tag   (pt_reg.box),
        .wr_stamp (qcnt_reg)
    );

    // directory write: hit refresh or allocation, in S_DEC
    logic alloc_free, alloc_low, do_hit;
    assign alloc_free = CW'(in_use_reg) < CW'(SLOTS - 1);
    assign alloc_low  = !alloc_free && have_low_reg;
    assign do_hit     = found_reg;
    assign dir_we     = (state_reg == S_DEC) && (do_hit || alloc_free || alloc_low);
    assign dir_widx   = do_hit ? slot_reg : (alloc_free ? SW'(in_use_reg) : low_i_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_axis_tvalid && s_axis_tready) state_next = S_TBL;
            S_TBL:   state_next = (op_reg == OP_QUERY) ? S_ENTRY : S_OUT;
            S_ENTRY:
            begin
                if (tbl_rd < 16'd2)
                    state_next = S_OUT;
                else if ({1'b0, pt_reg.box} == prev_box_reg)
                    state_next = S_WORD;
                else if (in_use_reg == '0)
                    state_next = S_DEC;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (dir_tag == pt_reg.box || scan_reg + 1'b1 >= in_use_reg)
                    state_next = S_DEC;
            end
            S_DEC:   state_next = found_reg ? S_WORD : S_OUT;
            S_WORD:  state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            in_use_reg <= '0;
            qcnt_reg <= '0;
            prev_box_reg <= '1;
            prev_slot_reg <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
            if (state_reg == S_TBL && op_reg == OP_QUERY)
                qcnt_reg <= qcnt_reg + 1'b1;
            if (state_reg == S_DEC)
            begin
                if (found_reg)
                begin
                    prev_box_reg <= {1'b0, pt_reg.box};
                    prev_slot_reg <= slot_reg;
                end
                else if (alloc_free || alloc_low)
                begin
                    prev_box_reg <= {1'b0, pt_reg.box};
                    prev_slot_reg <= dir_widx;
                    if (alloc_free)
                        in_use_reg <= in_use_reg + 1'b1;
                end
            end
            if (state_reg == S_OUT)
                m_axis_tvalid <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready)
        begin
            op_reg <= s_axis_tuser;
            pt_reg <= decode_point(s_axis_tdata[14:0], s_axis_tdata[30:15]);
            tidx_reg <= s_axis_tdata[46:31];
            tval_reg <= s_axis_tdata[61:47];
            fslot_reg <= s_axis_tdata[67:62];
            fword_reg <= s_axis_tdata[77:68];
            fdata_reg <= s_axis_tdata[93:78];
            status_reg <= ST_ACK;
            land_reg <= 1'b0;
            rec_reg <= '0;
            target_reg <= '0;
            box_out_reg <= '0;
        end
        case (state_reg)
            S_ENTRY:
            begin
                box_out_reg <= pt_reg.box;
                entry_reg <= tbl_rd[14:0];
                scan_reg <= '0;
                low_reg <= qcnt_reg;
                low_i_reg <= '0;
                have_low_reg <= 1'b0;
                found_reg <= 1'b0;
                slot_reg <= prev_slot_reg;
                if (tbl_rd < 16'd2)
                begin
                    status_reg <= ST_UNIFORM;
                    land_reg <= tbl_rd[0];
                end
            end
            S_SCAN:
            begin
                if (dir_tag == pt_reg.box)
                begin
                    found_reg <= 1'b1;
                    slot_reg <= SW'(scan_reg);
                end
                else if (dir_stamp < low_reg)
                begin
                    low_reg <= dir_stamp;
                    low_i_reg <= SW'(scan_reg);
                    have_low_reg <= 1'b1;
                end
                scan_reg <= scan_reg + 1'b1;
            end
            S_DEC:
            begin
                if (!found_reg)
                begin
                    if (alloc_free || alloc_low)
                    begin
                        status_reg <= ST_MISS;
                        rec_reg <= entry_reg;
                        target_reg <= 6'(dir_widx);
                    end
                    else
                        status_reg <= ST_NOSLOT;
                end
            end
            S_WORD:
            begin
                status_reg <= ST_HIT;
                land_reg <= 1'b0;
            end
            S_OUT:
            begin
                if (status_reg == ST_HIT)
                    land_reg <= word_rd[4'd15 - pt_reg.bit_sel];
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
